>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold whenever the guard is high.
`define ASSERT_WHEN(lbl, guard, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (guard) |-> (expr)) \
        else $error(msg);

`endif

>>> hdl/sc2a_pkg.sv
// Shared types, scan code constants and the key map for the set-1 decoder.
// No dependencies.
package sc2a_pkg;

    // opcode values
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // set-1 scan codes
    localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [7:0] SC_LSHIFT_MK = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_BK = 8'hB6;
    localparam logic [7:0] SC_LSHIFT_BK = 8'hAA;
    localparam logic [7:0] SC_CTRL_MK   = 8'h1D;
    localparam logic [7:0] SC_CTRL_BK   = 8'h9D;
    localparam logic [7:0] SC_ALT_MK    = 8'h38;
    localparam logic [7:0] SC_ALT_BK    = 8'hB8;
    localparam logic [7:0] SC_CAPS_MK   = 8'h3A;
    localparam logic [7:0] SC_NUM_MK    = 8'h45;
    localparam logic [7:0] SC_SCROLL_MK = 8'h46;
    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_F1_MK     = 8'h3B;
    localparam logic [7:0] SC_F10_MK    = 8'h44;
    localparam logic [7:0] SC_REL_LO    = 8'hBA;
    localparam logic [7:0] SC_REL_HI    = 8'hC6;
    localparam logic [7:0] SC_TABLE_END = 8'h54;
    localparam logic [7:0] CH_NONE      = 8'h80;

    localparam int FKEY_COUNT = 10;

    typedef struct packed {
        logic       opcode;
        logic [7:0] scan_code;
    } kbd_in_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_char;
        logic       led_write;
        logic [2:0] led_mask;
        logic       fkey_hit;
        logic [3:0] fkey_index;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       caps_on;
        logic       num_on;
        logic       scroll_on;
    } kbd_out_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } fifo_req_t;

    // Key map for make codes below the table end. Caps lock swaps the
    // shifted and unshifted forms of the letter keys and the backslash key.
    function automatic logic [7:0] keymap(input logic [6:0] code,
                                          input logic shift,
                                          input logic caps);
        logic [7:0] p;
        logic [7:0] s;
        logic       letter;
        logic       sel;
        p = CH_NONE;
        s = CH_NONE;
        letter = 1'b0;
        case (code)
            7'h00: begin p = 8'h00; s = 8'h00; end
            7'h01: begin p = 8'h1B; s = 8'h1B; end
            7'h02: begin p = 8'h31; s = 8'h21; end
            7'h03: begin p = 8'h32; s = 8'h40; end
            7'h04: begin p = 8'h33; s = 8'h23; end
            7'h05: begin p = 8'h34; s = 8'h24; end
            7'h06: begin p = 8'h35; s = 8'h25; end
            7'h07: begin p = 8'h36; s = 8'h5E; end
            7'h08: begin p = 8'h37; s = 8'h26; end
            7'h09: begin p = 8'h38; s = 8'h2A; end
            7'h0A: begin p = 8'h39; s = 8'h28; end
            7'h0B: begin p = 8'h30; s = 8'h29; end
            7'h0C: begin p = 8'h2D; s = 8'h5F; end
            7'h0D: begin p = 8'h3D; s = 8'h2B; end
            7'h0E: begin p = 8'h08; s = 8'h08; end
            7'h0F: begin p = 8'h09; s = 8'h09; end
            7'h10: begin p = 8'h71; letter = 1'b1; end
            7'h11: begin p = 8'h77; letter = 1'b1; end
            7'h12: begin p = 8'h65; letter = 1'b1; end
            7'h13: begin p = 8'h72; letter = 1'b1; end
            7'h14: begin p = 8'h74; letter = 1'b1; end
            7'h15: begin p = 8'h79; letter = 1'b1; end
            7'h16: begin p = 8'h75; letter = 1'b1; end
            7'h17: begin p = 8'h69; letter = 1'b1; end
            7'h18: begin p = 8'h6F; letter = 1'b1; end
            7'h19: begin p = 8'h70; letter = 1'b1; end
            7'h1A: begin p = 8'h5B; s = 8'h7B; end
            7'h1B: begin p = 8'h5D; s = 8'h7D; end
            7'h1C: begin p = 8'h0D; s = 8'h0D; end
            7'h1E: begin p = 8'h61; letter = 1'b1; end
            7'h1F: begin p = 8'h73; letter = 1'b1; end
            7'h20: begin p = 8'h64; letter = 1'b1; end
            7'h21: begin p = 8'h66; letter = 1'b1; end
            7'h22: begin p = 8'h67; letter = 1'b1; end
            7'h23: begin p = 8'h68; letter = 1'b1; end
            7'h24: begin p = 8'h6A; letter = 1'b1; end
            7'h25: begin p = 8'h6B; letter = 1'b1; end
            7'h26: begin p = 8'h6C; letter = 1'b1; end
            7'h27: begin p = 8'h3B; s = 8'h3A; end
            7'h28: begin p = 8'h27; s = 8'h22; end
            7'h29: begin p = 8'h60; s = 8'h7E; end
            7'h2B: begin p = 8'h5C; s = 8'h7C; end
            7'h2C: begin p = 8'h7A; letter = 1'b1; end
            7'h2D: begin p = 8'h78; letter = 1'b1; end
            7'h2E: begin p = 8'h63; letter = 1'b1; end
            7'h2F: begin p = 8'h76; letter = 1'b1; end
            7'h30: begin p = 8'h62; letter = 1'b1; end
            7'h31: begin p = 8'h6E; letter = 1'b1; end
            7'h32: begin p = 8'h6D; letter = 1'b1; end
            7'h33: begin p = 8'h2C; s = 8'h3C; end
            7'h34: begin p = 8'h2E; s = 8'h3E; end
            7'h35: begin p = 8'h2F; s = 8'h3F; end
            7'h37: begin p = 8'h2A; s = 8'h2A; end
            7'h39: begin p = 8'h20; s = 8'h20; end
            7'h47: begin s = 8'h37; end
            7'h48: begin s = 8'h38; end
            7'h49: begin s = 8'h39; end
            7'h4B: begin s = 8'h34; end
            7'h4C: begin s = 8'h35; end
            7'h4D: begin s = 8'h36; end
            7'h4F: begin s = 8'h31; end
            7'h50: begin s = 8'h32; end
            7'h51: begin s = 8'h33; end
            7'h52: begin p = 8'h30; s = 8'h30; end
            7'h53: begin p = 8'h7F; s = 8'h7F; end
            default: begin p = CH_NONE; s = CH_NONE; end
        endcase
        if (letter) begin
            s = p ^ 8'h20;
        end
        sel = shift ^ (caps & (letter | (code == 7'h2B)));
        return sel ? s : p;
    endfunction

endpackage

>>> hdl/sc2a_decode.sv
// Scan code decoder: modifier and lock flags, release arming, F-key report,
// key map lookup and FIFO push/pop requests. Depends on sc2a_pkg.
module sc2a_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                proc,
    input  sc2a_pkg::kbd_in_t   item,
    input  logic                cfg_we,
    input  logic [9:0]          cfg_data,
    input  logic                fifo_empty,
    output sc2a_pkg::fifo_req_t fifo_req,
    output sc2a_pkg::kbd_out_t  res
);

    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       alt_reg, alt_next;
    logic       caps_reg, caps_next;
    logic       num_reg, num_next;
    logic       scroll_reg, scroll_next;
    logic       armed_reg, armed_next;
    logic [9:0] fkey_en_reg;

    logic       push_c;
    logic       led_c;
    logic       fhit_c;
    logic [3:0] fidx_c;
    logic [7:0] fk_off;
    logic [7:0] ch_c;
    logic       rd_c;

    assign fk_off = item.scan_code - sc2a_pkg::SC_F1_MK;
    assign rd_c   = (item.opcode == sc2a_pkg::OP_READ) && !fifo_empty;

    always_comb
    begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        caps_next   = caps_reg;
        num_next    = num_reg;
        scroll_next = scroll_reg;
        armed_next  = armed_reg;
        push_c      = 1'b0;
        led_c       = 1'b0;
        fhit_c      = 1'b0;
        fidx_c      = 4'd0;
        ch_c        = sc2a_pkg::CH_NONE;
        if (item.opcode == sc2a_pkg::OP_SCAN)
        begin
            case (item.scan_code)
                sc2a_pkg::SC_RSHIFT_MK, sc2a_pkg::SC_LSHIFT_MK: shift_next = 1'b1;
                sc2a_pkg::SC_RSHIFT_BK, sc2a_pkg::SC_LSHIFT_BK: shift_next = 1'b0;
                sc2a_pkg::SC_CTRL_MK: ctrl_next = 1'b1;
                sc2a_pkg::SC_CTRL_BK: ctrl_next = 1'b0;
                sc2a_pkg::SC_ALT_MK:  alt_next  = 1'b1;
                sc2a_pkg::SC_ALT_BK:  alt_next  = 1'b0;
                sc2a_pkg::SC_CAPS_MK:
                begin
                    if (armed_reg)
                    begin
                        caps_next  = ~caps_reg;
                        armed_next = 1'b0;
                        led_c      = 1'b1;
                    end
                end
                sc2a_pkg::SC_NUM_MK:
                begin
                    if (armed_reg)
                    begin
                        num_next   = ~num_reg;
                        armed_next = 1'b0;
                        led_c      = 1'b1;
                    end
                end
                sc2a_pkg::SC_SCROLL_MK:
                begin
                    if (armed_reg)
                    begin
                        scroll_next = ~scroll_reg;
                        armed_next  = 1'b0;
                        led_c       = 1'b1;
                    end
                end
                default:
                begin
                    if (item.scan_code >= sc2a_pkg::SC_F1_MK &&
                        item.scan_code <= sc2a_pkg::SC_F10_MK)
                    begin
                        if (armed_reg && fkey_en_reg[fk_off[3:0]])
                        begin
                            fhit_c     = 1'b1;
                            fidx_c     = fk_off[3:0];
                            armed_next = 1'b0;
                        end
                    end
                    else if (item.scan_code >= sc2a_pkg::SC_REL_LO &&
                             item.scan_code <= sc2a_pkg::SC_REL_HI)
                    begin
                        armed_next = 1'b1;
                    end
                    else if (item.scan_code == sc2a_pkg::SC_PREFIX ||
                             item.scan_code[7])
                    begin
                        // prefix or unrelated break code
                    end
                    else
                    begin
                        push_c = 1'b1;
                        if (item.scan_code < sc2a_pkg::SC_TABLE_END)
                        begin
                            ch_c = sc2a_pkg::keymap(item.scan_code[6:0],
                                                    shift_reg, caps_reg);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= 1'b0;
            ctrl_reg    <= 1'b0;
            alt_reg     <= 1'b0;
            caps_reg    <= 1'b0;
            num_reg     <= 1'b0;
            scroll_reg  <= 1'b0;
            armed_reg   <= 1'b1;
            fkey_en_reg <= 10'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                fkey_en_reg <= cfg_data;
            end
            if (proc)
            begin
                shift_reg  <= shift_next;
                ctrl_reg   <= ctrl_next;
                alt_reg    <= alt_next;
                caps_reg   <= caps_next;
                num_reg    <= num_next;
                scroll_reg <= scroll_next;
                armed_reg  <= armed_next;
            end
        end
    end

    assign fifo_req.push = proc & push_c;
    assign fifo_req.pop  = proc & rd_c;
    assign fifo_req.data = ch_c;

    // read_char is filled in from the FIFO's registered read data
    assign res.read_valid = rd_c;
    assign res.read_char  = 8'd0;
    assign res.led_write  = led_c;
    assign res.led_mask   = {caps_next, num_next, scroll_next};
    assign res.fkey_hit   = fhit_c;
    assign res.fkey_index = fidx_c;
    assign res.shift_held = shift_next;
    assign res.ctrl_held  = ctrl_next;
    assign res.alt_held   = alt_next;
    assign res.caps_on    = caps_next;
    assign res.num_on     = num_next;
    assign res.scroll_on  = scroll_next;

endmodule

>>> hdl/sc2a_fifo.sv
// Circular character FIFO; a push into a full FIFO replaces the newest entry.
// Read data is registered on a pop. Depends on sc2a_pkg.
module sc2a_fifo
#(
    parameter int FIFO_DEPTH = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sc2a_pkg::fifo_req_t req,
    output logic                empty,
    output logic [7:0]          rd_data
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(FIFO_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
    localparam logic [AW:0]   LAST_OFF = (AW + 1)'(FIFO_DEPTH - 1);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [7:0]    rd_data_reg;

    logic          full;
    logic [AW:0]   wr_off;
    logic [AW:0]   wr_sum;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   head_inc;
    logic [AW-1:0] head_next;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    // full: overwrite the newest slot, else write just past it
    assign wr_off  = full ? LAST_OFF : (AW + 1)'(count_reg);
    assign wr_sum  = {1'b0, head_reg} + wr_off;
    assign wr_addr = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];

    assign head_inc  = {1'b0, head_reg} + (AW + 1)'(1);
    assign head_next = (head_inc == DEPTH_W) ? '0 : head_inc[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wr_addr] <= req.data;
        end
        if (req.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (req.pop)
        begin
            head_reg  <= head_next;
            count_reg <= count_reg - CW'(1);
        end
        else if (req.push && !full)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/scancode_to_ascii_keyboard_decoder_core.sv
// Top level of the set-1 scan code decoder: input register, decoder,
// character FIFO and result register. Depends on sc2a_pkg, sc2a_decode, sc2a_fifo.
//
// Usage:
//   in_*  : one beat per item; opcode 0 carries a scan code byte, opcode 1
//           asks for one character from the FIFO.
//   out_* : exactly one result beat per input beat, in order.
//   cfg_* : writes fkey_enable; always ready, write only while idle.
// Path: input register, then result register. Throughput: one item per
//   cycle unless a low out_ready stalls; the decode path is one key map lookup
//   plus flag logic, and the FIFO memory takes one push or one pop per cycle.
// Stall: while out_ready is low the result holds and the input register
//   still takes one more beat; in_ready drops only when both are full.
// Reset: modifier and lock flags clear, release arming is set, the FIFO is
//   empty and fkey_enable is zero. FIFO contents are not cleared; no
//   clearing pass is needed since only written entries are ever read.
module scancode_to_ascii_keyboard_decoder_core
#(
    parameter int FIFO_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sc2a_pkg::kbd_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sc2a_pkg::kbd_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [9:0]         cfg_data
);

    // input stage
    logic               in_valid_reg;
    sc2a_pkg::kbd_in_t  in_data_reg;

    // result stage (read_char comes from the FIFO read register)
    logic               out_valid_reg;
    sc2a_pkg::kbd_out_t res_reg;

    logic               advance;
    logic               proc;
    logic               fifo_empty;
    logic [7:0]         fifo_rd_data;
    sc2a_pkg::fifo_req_t fifo_req;
    sc2a_pkg::kbd_out_t dec_res;

    // result stage moves when it is empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign proc     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (proc)
        begin
            res_reg <= dec_res;
        end
    end

    sc2a_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc       (proc),
        .item       (in_data_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .fifo_empty (fifo_empty),
        .fifo_req   (fifo_req),
        .res        (dec_res)
    );

    sc2a_fifo
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fifo_req),
        .empty   (fifo_empty),
        .rd_data (fifo_rd_data)
    );

    // merge the popped character into the result
    always_comb
    begin
        out_data = res_reg;
        out_data.read_char = res_reg.read_valid ? fifo_rd_data : 8'd0;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/sc2a_checker.sv
// Port-level checks for the scan code decoder, bound to the top level.
// Depends on sc2a_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sc2a_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input sc2a_pkg::kbd_out_t out_data
);

    `ASSERT_PROP(a_in_hold, in_valid && !in_ready |=> in_valid, "input beat withdrawn early")
    `ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> $stable(out_data), "stalled result changed")
    `ASSERT_WHEN(a_char_zero, out_valid, out_data.read_valid || out_data.read_char == 8'd0, "read_char set without read_valid")
    `ASSERT_WHEN(a_led_track, out_valid, out_data.led_mask == {out_data.caps_on, out_data.num_on, out_data.scroll_on}, "led mask disagrees with lock flags")
    `ASSERT_WHEN(a_fkey_idx, out_valid, out_data.fkey_hit ? (out_data.fkey_index <= 4'd9) : (out_data.fkey_index == 4'd0), "bad function key index")

endmodule

bind scancode_to_ascii_keyboard_decoder_core sc2a_checker u_sc2a_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> bench/scancode_to_ascii_keyboard_decoder_core_tb.sv
// Self-checking bench for the set-1 scan code decoder core: a scoreboard class
// predicts every result beat; plain tasks drive the in, out and cfg channels.
// Depends on sc2a_pkg and scancode_to_ascii_keyboard_decoder_core.
module scancode_to_ascii_keyboard_decoder_core_tb;

    localparam int RING_DEPTH   = 128;
    localparam int PHASE_ITEMS  = 385;    // five random phases, ~1925 items in all
    localparam int STALL_LIMIT  = 2000;   // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
    localparam int IDLE_PCT     = 29;

    // LED mask bits; the lock flags always equal these bits
    localparam bit [2:0] LED_SCROLL = 3'b001;
    localparam bit [2:0] LED_NUM    = 3'b010;
    localparam bit [2:0] LED_CAPS   = 3'b100;

    // Key maps for make codes 0x00..0x53, unshifted and shifted, one row
    // per keyboard region. Element 0 sits in the leftmost byte.
    localparam bit [0:83][7:0] PLAIN_KEYS = {
        128'h00_1B_31_32_33_34_35_36_37_38_39_30_2D_3D_08_09,
        112'h71_77_65_72_74_79_75_69_6F_70_5B_5D_0D_80,
        104'h61_73_64_66_67_68_6A_6B_6C_3B_27_60_80,
        96'h5C_7A_78_63_76_62_6E_6D_2C_2E_2F_80,
        96'h2A_80_20_80_80_80_80_80_80_80_80_80,
        136'h80_80_80_80_80_80_80_80_80_80_80_80_80_80_80_30_7F
    };
    localparam bit [0:83][7:0] SHIFTED_KEYS = {
        128'h00_1B_21_40_23_24_25_5E_26_2A_28_29_5F_2B_08_09,
        112'h51_57_45_52_54_59_55_49_4F_50_7B_7D_0D_80,
        104'h41_53_44_46_47_48_4A_4B_4C_3A_22_7E_80,
        96'h7C_5A_58_43_56_42_4E_4D_3C_3E_3F_80,
        96'h2A_80_20_80_80_80_80_80_80_80_80_80,
        136'h80_80_80_80_37_38_39_80_34_35_36_80_31_32_33_30_7F
    };

    // Tracks modifier, lock and FIFO state and holds the result beats that
    // the accepted input beats call for, oldest first.
    class keyboard_tracker;
        bit                 shift_on;
        bit                 ctrl_on;
        bit                 alt_on;
        bit                 armed;
        bit [2:0]           led_bits;
        bit [9:0]           fkey_mask;
        bit [7:0]           char_ring [RING_DEPTH];
        int unsigned        ring_head;
        int unsigned        ring_fill;
        sc2a_pkg::kbd_out_t due_results [$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        chars_read;
        int unsigned        empty_reads;
        int unsigned        led_updates;
        int unsigned        fkey_reports;
        int unsigned        overwrites;

        function new();
            armed = 1'b1;
        endfunction

        function void set_fkey_mask(bit [9:0] mask);
            fkey_mask = mask;
        endfunction

        // Caps lock swaps the two forms only for letters and backslash.
        function bit [7:0] map_key(bit [7:0] code);
            bit swap;
            if (code >= sc2a_pkg::SC_TABLE_END)
                return sc2a_pkg::CH_NONE;
            swap = led_bits[2] && ((code >= 8'h10 && code <= 8'h19) ||
                                   (code >= 8'h1E && code <= 8'h26) ||
                                   (code >= 8'h2B && code <= 8'h32));
            return (shift_on ^ swap) ? SHIFTED_KEYS[code[6:0]] : PLAIN_KEYS[code[6:0]];
        endfunction

        function bit toggle_lock(bit [2:0] led);
            if (!armed)
                return 1'b0;
            led_bits ^= led;
            armed = 1'b0;
            led_updates++;
            return 1'b1;
        endfunction

        // Full ring: the newest entry is replaced, fill stays at depth.
        function void push_char(bit [7:0] ch);
            if (ring_fill < RING_DEPTH)
                ring_fill++;
            else
                overwrites++;
            char_ring[(ring_head + ring_fill - 1) % RING_DEPTH] = ch;
        endfunction

        // Notes one accepted input beat; returns 0 for a prefix byte or stray break code.
        function bit apply_key_beat(sc2a_pkg::kbd_in_t beat);
            sc2a_pkg::kbd_out_t r;
            bit                 acted;
            bit [3:0]           k;
            r = '0;
            acted = 1'b1;
            if (beat.opcode == sc2a_pkg::OP_READ)
            begin
                if (ring_fill != 0)
                begin
                    r.read_valid = 1'b1;
                    r.read_char  = char_ring[ring_head];
                    ring_head    = (ring_head + 1) % RING_DEPTH;
                    ring_fill--;
                    chars_read++;
                end
                else
                    empty_reads++;
            end
            else
            begin
                case (beat.scan_code)
                    sc2a_pkg::SC_RSHIFT_MK, sc2a_pkg::SC_LSHIFT_MK: shift_on = 1'b1;
                    sc2a_pkg::SC_RSHIFT_BK, sc2a_pkg::SC_LSHIFT_BK: shift_on = 1'b0;
                    sc2a_pkg::SC_CTRL_MK:   ctrl_on = 1'b1;
                    sc2a_pkg::SC_CTRL_BK:   ctrl_on = 1'b0;
                    sc2a_pkg::SC_ALT_MK:    alt_on  = 1'b1;
                    sc2a_pkg::SC_ALT_BK:    alt_on  = 1'b0;
                    sc2a_pkg::SC_CAPS_MK:   r.led_write = toggle_lock(LED_CAPS);
                    sc2a_pkg::SC_NUM_MK:    r.led_write = toggle_lock(LED_NUM);
                    sc2a_pkg::SC_SCROLL_MK: r.led_write = toggle_lock(LED_SCROLL);
                    default:
                    begin
                        if (beat.scan_code >= sc2a_pkg::SC_F1_MK &&
                            beat.scan_code <= sc2a_pkg::SC_F10_MK)
                        begin
                            k = 4'(beat.scan_code - sc2a_pkg::SC_F1_MK);
                            if (armed && fkey_mask[k])
                            begin
                                r.fkey_hit   = 1'b1;
                                r.fkey_index = k;
                                armed = 1'b0;
                                fkey_reports++;
                            end
                        end
                        else if (beat.scan_code >= sc2a_pkg::SC_REL_LO &&
                                 beat.scan_code <= sc2a_pkg::SC_REL_HI)
                            armed = 1'b1;
                        else if (beat.scan_code >= 8'h80)
                            acted = 1'b0;    // prefix byte or other break code
                        else
                            push_char(map_key(beat.scan_code));
                    end
                endcase
            end
            r.led_mask   = led_bits;
            r.shift_held = shift_on;
            r.ctrl_held  = ctrl_on;
            r.alt_held   = alt_on;
            r.caps_on    = led_bits[2];
            r.num_on     = led_bits[1];
            r.scroll_on  = led_bits[0];
            due_results.push_back(r);
            return acted;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_result(sc2a_pkg::kbd_out_t got);
            sc2a_pkg::kbd_out_t want;
            if (due_results.size() == 0)
            begin
                $error("result beat %h arrived with no input beat pending", got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            results_seen++;
            check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            check_field("read_char",  want.read_char,      got.read_char);
            check_field("led_write",  8'(want.led_write),  8'(got.led_write));
            check_field("led_mask",   8'(want.led_mask),   8'(got.led_mask));
            check_field("fkey_hit",   8'(want.fkey_hit),   8'(got.fkey_hit));
            check_field("fkey_index", 8'(want.fkey_index), 8'(got.fkey_index));
            check_field("shift_held", 8'(want.shift_held), 8'(got.shift_held));
            check_field("ctrl_held",  8'(want.ctrl_held),  8'(got.ctrl_held));
            check_field("alt_held",   8'(want.alt_held),   8'(got.alt_held));
            check_field("caps_on",    8'(want.caps_on),    8'(got.caps_on));
            check_field("num_on",     8'(want.num_on),     8'(got.num_on));
            check_field("scroll_on",  8'(want.scroll_on),  8'(got.scroll_on));
        endfunction
    endclass

    // Every block input starts at a known value; reset is held from time 0.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    sc2a_pkg::kbd_in_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sc2a_pkg::kbd_out_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [9:0]         cfg_data  = '0;

    keyboard_tracker tracker = new();

    int unsigned feed_idle_pct   = IDLE_PCT;
    int unsigned drain_idle_pct  = IDLE_PCT;
    bit          hold_off_request = 1'b0;
    int unsigned items_sent      = 0;
    int unsigned effective_items = 0;
    int unsigned quiet_cycles    = 0;

    always #5 clk = ~clk;

    scancode_to_ascii_keyboard_decoder_core #(
        .FIFO_DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Input beat: optional idle cycles, then valid held until accepted.
    // Each call starts and ends in a rising-edge time step, so valid is
    // driven once per step and never dropped between back-to-back beats.
    task automatic send_item(input sc2a_pkg::kbd_in_t beat);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (tracker.apply_key_beat(beat))
            effective_items++;
    endtask

    task automatic send_scan(input logic [7:0] code);
        sc2a_pkg::kbd_in_t beat;
        beat.opcode    = sc2a_pkg::OP_SCAN;
        beat.scan_code = code;
        send_item(beat);
    endtask

    // Read request; the scan code byte rides along as don't-care noise.
    task automatic send_read();
        sc2a_pkg::kbd_in_t beat;
        beat.opcode    = sc2a_pkg::OP_READ;
        beat.scan_code = 8'($urandom_range(255));
        send_item(beat);
    endtask

    // Mostly keys inside the map, now and then one past its end.
    function automatic logic [7:0] typed_code();
        if ($urandom_range(99) < 88)
            return 8'($urandom_range(8'h53));
        return 8'($urandom_range(8'h7F, 8'h54));
    endfunction

    // Quiet the input and wait until every expected result beat is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_fkey_mask(input logic [9:0] mask);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_fkey_mask(mask);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic built mostly from well-formed key sequences: typed runs
    // (sometimes under shift), read bursts, lock and F-key taps with their
    // release codes, modifier changes, plus raw noise beats. A rare flood
    // pushes past the FIFO depth so the overwrite path gets exercised.
    task automatic run_random_phase(input int unsigned target, input bit flood_first);
        int unsigned start;
        int unsigned roll;
        int unsigned n;
        bit          shifted;
        logic [7:0]  code;
        start = effective_items;
        while (effective_items - start < target)
        begin
            roll = flood_first ? 0 : $urandom_range(999);
            flood_first = 1'b0;
            if (roll < 4)
            begin
                n = RING_DEPTH + $urandom_range(8, 1);
                repeat (n) send_scan(typed_code());
                repeat (n + 4) send_read();
            end
            else if (roll < 320)
            begin
                shifted = 1'($urandom_range(1));
                if (shifted)
                    send_scan($urandom_range(1) ? sc2a_pkg::SC_LSHIFT_MK
                                                : sc2a_pkg::SC_RSHIFT_MK);
                repeat ($urandom_range(8, 1)) send_scan(typed_code());
                if (shifted)
                    send_scan($urandom_range(1) ? sc2a_pkg::SC_LSHIFT_BK
                                                : sc2a_pkg::SC_RSHIFT_BK);
            end
            else if (roll < 550)
            begin
                repeat ($urandom_range(12, 1)) send_read();
            end
            else if (roll < 650)
            begin
                case ($urandom_range(2))
                    0:       send_scan(sc2a_pkg::SC_CAPS_MK);
                    1:       send_scan(sc2a_pkg::SC_NUM_MK);
                    default: send_scan(sc2a_pkg::SC_SCROLL_MK);
                endcase
                if ($urandom_range(99) < 80)
                    send_scan(8'($urandom_range(sc2a_pkg::SC_REL_HI, sc2a_pkg::SC_REL_LO)));
            end
            else if (roll < 740)
            begin
                send_scan(8'(sc2a_pkg::SC_F1_MK +
                             $urandom_range(sc2a_pkg::FKEY_COUNT - 1)));
                if ($urandom_range(99) < 80)
                    send_scan(8'($urandom_range(sc2a_pkg::SC_REL_HI, sc2a_pkg::SC_REL_LO)));
            end
            else if (roll < 840)
            begin
                case ($urandom_range(3))
                    0:       code = $urandom_range(1) ? sc2a_pkg::SC_LSHIFT_MK
                                                      : sc2a_pkg::SC_RSHIFT_MK;
                    1:       code = $urandom_range(1) ? sc2a_pkg::SC_LSHIFT_BK
                                                      : sc2a_pkg::SC_RSHIFT_BK;
                    2:       code = $urandom_range(1) ? sc2a_pkg::SC_CTRL_MK
                                                      : sc2a_pkg::SC_CTRL_BK;
                    default: code = $urandom_range(1) ? sc2a_pkg::SC_ALT_MK
                                                      : sc2a_pkg::SC_ALT_BK;
                endcase
                send_scan(code);
            end
            else
            begin
                // raw noise: any opcode, any byte, prefix and stray breaks too
                if ($urandom_range(1))
                    send_read();
                else if ($urandom_range(3) == 0)
                    send_scan(sc2a_pkg::SC_PREFIX);
                else
                    send_scan(8'($urandom_range(255)));
            end
        end
    endtask

    // Receiver: checks each accepted result beat, then picks the next ready.
    // A hold-off request keeps ready low for a long stretch, counted here.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.compare_result(out_data);
            if (hold_off_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    // Watchdog: a stretch with no beat on any channel ends the run once it reaches the stall limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [9:0] phase_masks [0:4];
        phase_masks[0] = 10'h3FF;
        phase_masks[1] = 10'h000;
        phase_masks[2] = 10'h2AA;
        phase_masks[3] = 10'($urandom_range(1023));
        phase_masks[4] = 10'h201;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // F1, F3, F5, F7, F9 enabled for the directed part
        write_fkey_mask(10'h155);

        send_read();                                // empty FIFO read
        send_scan(8'h00);                           // lowest make code
        send_scan(sc2a_pkg::SC_TABLE_END);          // past the map: 0x80
        send_scan(8'h7F);                           // top make code, also past the map
        send_scan(sc2a_pkg::SC_LSHIFT_MK);
        send_scan(8'h10);                           // 'Q'
        send_scan(8'h2B);                           // '|'
        send_scan(sc2a_pkg::SC_LSHIFT_BK);
        send_scan(sc2a_pkg::SC_CAPS_MK);            // caps on, disarms
        send_scan(8'h1E);                           // 'A' under caps
        send_scan(sc2a_pkg::SC_RSHIFT_MK);
        send_scan(8'h1E);                           // caps + shift: 'a'
        send_scan(8'h47);                           // shifted keypad '7'
        send_scan(sc2a_pkg::SC_RSHIFT_BK);
        send_scan(sc2a_pkg::SC_NUM_MK);             // disarmed lock press: no effect
        send_scan(sc2a_pkg::SC_F1_MK);              // disarmed F-key press: no effect
        send_scan(sc2a_pkg::SC_REL_LO);
        send_scan(sc2a_pkg::SC_NUM_MK);
        send_scan(sc2a_pkg::SC_REL_HI);
        send_scan(sc2a_pkg::SC_SCROLL_MK);          // scroll flag, not num
        send_scan(sc2a_pkg::SC_REL_LO + 8'd3);
        send_scan(sc2a_pkg::SC_F10_MK);             // disabled F-key: no effect
        send_scan(sc2a_pkg::SC_F1_MK);              // reported, index 0
        send_scan(sc2a_pkg::SC_CTRL_MK);
        send_scan(sc2a_pkg::SC_ALT_MK);
        send_scan(sc2a_pkg::SC_PREFIX);
        send_scan(8'hFF);                           // stray break code
        drain_results();
        repeat (4) @(posedge clk);

        for (int p = 0; p < 5; p++)
        begin
            write_fkey_mask(phase_masks[p]);
            if (p == 1)
            begin
                // no idling on either side, and the receiver stalls long
                // enough that the block fills and drops in_ready
                feed_idle_pct    = 0;
                drain_idle_pct   = 0;
                hold_off_request = 1'b1;
            end
            else
            begin
                feed_idle_pct  = IDLE_PCT;
                drain_idle_pct = IDLE_PCT;
            end
            run_random_phase(PHASE_ITEMS, p == 2);
            drain_results();
            repeat (4) @(posedge clk);
        end

        $display("Sent %0d input beats (%0d acted on), checked %0d result beats.",
                 items_sent, effective_items, tracker.results_seen);
        $display("Reads %0d hit / %0d empty, LED updates %0d, F-key reports %0d, overwrites %0d.",
                 tracker.chars_read, tracker.empty_reads, tracker.led_updates,
                 tracker.fkey_reports, tracker.overwrites);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
